FILE: hdl/urfpc_pkg.sv
`default_nettype none

package urfpc_pkg;

    // Default depth of the receive byte ring (holds one byte fewer)
    localparam int FIFO_DEPTH_DEF = 16;

    // Depths of the internal queues
    localparam int CMD_Q_DEPTH = 2;
    localparam int RES_Q_DEPTH = 4;
    localparam int RES_CNT_W   = $clog2(RES_Q_DEPTH + 1);

    // Configuration register indexes
    localparam logic CFG_PARITY_ENABLE = 1'b0;
    localparam logic CFG_PARITY_SENSE  = 1'b1;

    typedef enum logic [1:0] {
        MODE_RX    = 2'd0,
        MODE_RD    = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_TX    = 2'd3
    } mode_t;

    // Buffer status codes
    localparam logic [1:0] BSTAT_OK    = 2'd0;
    localparam logic [1:0] BSTAT_FULL  = 2'd1;
    localparam logic [1:0] BSTAT_EMPTY = 2'd2;

    // Stored receive error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_FULL   = 2'd1;
    localparam logic [1:0] ERR_PARITY = 2'd2;

    // Classified command handed from front to back
    typedef struct packed {
        mode_t      mode;
        logic [7:0] data;
        logic       par_bit;   // fold(data) ^ sense
        logic       par_err;   // receive parity check failed
    } cmd_t;

    // One result transaction
    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] buffer_status;
        logic [1:0] rx_error;
        logic       data_available;
        logic [8:0] tx_word;
    } res_t;

    // XOR fold of a byte
    function automatic logic fold_parity(input logic [7:0] b);
        return ^b;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/uart_rx_fifo_parity_check_top.sv
// UART receive byte ring with ninth-bit parity check and transmit encoder.
// Input channel: a transaction (mode, data_byte, ninth_bit) is taken on a
// rising edge with push high and full low. Modes: receive byte, read byte,
// flush, encode transmit word.
// Result channel: while empty is low the oldest result sits on read_data,
// buffer_status, rx_error, data_available and tx_word; pop takes it.
// Every input transaction yields exactly one result, in order.
// A result passes the command queue, result stage and result queue in turn.
// Throughput: one transaction per cycle unless stalled, set by the single
// ring write or read port in the back end; a 2-entry command queue and a
// 4-entry result queue let either side stall without stalling the other.
// If the receiver stops popping, the result queue fills, the back end stops
// issuing, the command queue fills and full rises.
// Configuration: cfg_we/cfg_index/cfg_data write parity_enable (index 0)
// and parity_sense (index 1); the user must write only while the block is
// idle (not enforced). Reset (rst_n low, async): ring empty, error cleared,
// parity disabled, even sense. Ring contents are not cleared.
`default_nettype none

module uart_rx_fifo_parity_check_top #(
    parameter int FIFO_DEPTH = urfpc_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic        ninth_bit,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       read_data,
    output logic [1:0]       buffer_status,
    output logic [1:0]       rx_error,
    output logic             data_available,
    output logic [8:0]       tx_word
);

    import urfpc_pkg::*;

    cmd_t                         front_cmd;
    logic [$bits(cmd_t)-1:0]      cmdq_out;
    logic                         cmdq_empty;
    logic [$clog2(CMD_Q_DEPTH+1)-1:0] cmdq_count;
    logic                         cmd_pop;
    logic                         res_push;
    res_t                         back_res;
    logic [$bits(res_t)-1:0]      resq_out;
    logic                         resq_full;
    logic [RES_CNT_W-1:0]         resq_count;
    res_t                         out_res;

    // Front end: config and classification
    urfpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mode      (mode),
        .data_byte (data_byte),
        .ninth_bit (ninth_bit),
        .cmd       (front_cmd)
    );

    // Command queue between front and back
    urfpc_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (front_cmd),
        .full     (full),
        .pop      (cmd_pop),
        .data_out (cmdq_out),
        .empty    (cmdq_empty),
        .count    (cmdq_count)
    );

    // Back end: ring, pointers, error status
    urfpc_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmdq_empty && (cmdq_count != '0)),
        .cmd       (cmd_t'(cmdq_out)),
        .cmd_pop   (cmd_pop),
        .res_count (resq_count),
        .res_push  (res_push),
        .res       (back_res)
    );

    // Result queue toward the receiver
    urfpc_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data_in  (back_res),
        .full     (resq_full),
        .pop      (pop),
        .data_out (resq_out),
        .empty    (empty),
        .count    (resq_count)
    );

    assign out_res        = res_t'(resq_out);
    assign read_data      = out_res.read_data;
    assign buffer_status  = out_res.buffer_status;
    assign rx_error       = out_res.rx_error;
    assign data_available = out_res.data_available;
    assign tx_word        = resq_full ? out_res.tx_word : out_res.tx_word;

endmodule

`default_nettype wire

FILE: hdl/urfpc_queue.sv
`default_nettype none

module urfpc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [WIDTH-1:0]             data_in,
    output logic                              full,
    input  wire logic                         pop,
    output logic [WIDTH-1:0]                  data_out,
    output logic                              empty,
    output logic [$clog2(DEPTH+1)-1:0]        count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign data_out = store[head_reg];
    assign push_ok  = push && !full;
    assign pop_ok   = pop && !empty;

    // Pointer and occupancy update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push_ok)
        begin
            tail_next = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop_ok)
        begin
            head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            store[tail_reg] <= data_in;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/urfpc_front.sv
`default_nettype none

module urfpc_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic        ninth_bit,
    output urfpc_pkg::cmd_t  cmd
);

    import urfpc_pkg::*;

    logic parity_enable_reg;
    logic parity_sense_reg;
    logic par_bit;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_enable_reg <= 1'b0;
            parity_sense_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PARITY_ENABLE: parity_enable_reg <= cfg_data;
                CFG_PARITY_SENSE:  parity_sense_reg  <= cfg_data;
                default:           parity_enable_reg <= parity_enable_reg;
            endcase
        end
    end

    // Classify: parity bit for both receive check and transmit encode
    assign par_bit     = fold_parity(data_byte) ^ parity_sense_reg;
    assign cmd.mode    = mode_t'(mode);
    assign cmd.data    = data_byte;
    assign cmd.par_bit = par_bit;
    assign cmd.par_err = parity_enable_reg && (par_bit != ninth_bit);

endmodule

`default_nettype wire

FILE: hdl/urfpc_back.sv
`default_nettype none

module urfpc_back #(
    parameter int FIFO_DEPTH = urfpc_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    input  wire urfpc_pkg::cmd_t                  cmd,
    output logic                                  cmd_pop,
    input  wire logic [urfpc_pkg::RES_CNT_W-1:0]  res_count,
    output logic                                  res_push,
    output urfpc_pkg::res_t                       res
);

    import urfpc_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [7:0]       ring [FIFO_DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [1:0]       err_reg, err_next;
    logic [PTR_W-1:0] wp_inc, rp_inc;
    logic             go;
    logic             ring_we, ring_re;
    logic [7:0]       rd_reg;

    // Result stage
    logic             s1_valid_reg;
    logic             s1_pop_reg, s1_pop_next;
    logic [1:0]       s1_bstat_reg, s1_bstat_next;
    logic [1:0]       s1_err_reg;
    logic             s1_avail_reg;
    logic [8:0]       s1_tx_reg, s1_tx_next;

    // Issue only with room for this and the in-flight result downstream
    assign go = cmd_valid &&
                (({1'b0, res_count} + {{RES_CNT_W{1'b0}}, s1_valid_reg})
                 < (RES_CNT_W + 1)'(RES_Q_DEPTH));
    assign cmd_pop = go;

    assign wp_inc = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;

    // Command execution against the ring
    always_comb
    begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        err_next      = err_reg;
        ring_we       = 1'b0;
        ring_re       = 1'b0;
        s1_pop_next   = 1'b0;
        s1_bstat_next = BSTAT_OK;
        s1_tx_next    = '0;
        if (go)
        begin
            case (cmd.mode)
                MODE_RX:
                begin
                    if (wp_inc == rp_reg)
                    begin
                        s1_bstat_next = BSTAT_FULL;
                        err_next      = ERR_FULL;
                    end
                    else
                    begin
                        ring_we  = 1'b1;
                        wp_next  = wp_inc;
                        err_next = ERR_NONE;
                    end
                    if (cmd.par_err)
                    begin
                        err_next = ERR_PARITY;
                    end
                end
                MODE_RD:
                begin
                    if (wp_reg == rp_reg)
                    begin
                        s1_bstat_next = BSTAT_EMPTY;
                    end
                    else
                    begin
                        ring_re     = 1'b1;
                        s1_pop_next = 1'b1;
                        rp_next     = rp_inc;
                    end
                end
                MODE_FLUSH:
                begin
                    wp_next  = '0;
                    rp_next  = '0;
                    err_next = ERR_NONE;
                end
                MODE_TX:
                begin
                    s1_tx_next = {cmd.par_bit, cmd.data};
                end
                default:
                begin
                    s1_tx_next = '0;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            err_reg      <= ERR_NONE;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            err_reg      <= err_next;
            s1_valid_reg <= go;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_pop_reg   <= s1_pop_next;
            s1_bstat_reg <= s1_bstat_next;
            s1_err_reg   <= err_next;
            s1_avail_reg <= (wp_next != rp_next);
            s1_tx_reg    <= s1_tx_next;
        end
    end

    // Byte ring, registered read
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[wp_reg] <= cmd.data;
        end
        if (ring_re)
        begin
            rd_reg <= ring[rp_reg];
        end
    end

    assign res_push           = s1_valid_reg;
    assign res.read_data      = s1_pop_reg ? rd_reg : 8'd0;
    assign res.buffer_status  = s1_bstat_reg;
    assign res.rx_error       = s1_err_reg;
    assign res.data_available = s1_avail_reg;
    assign res.tx_word        = s1_tx_reg;

endmodule

`default_nettype wire
